// ===== rtl/core/wpi_pkg.sv =====
`default_nettype none
package wpi_pkg;
    localparam int unsigned MaxInserted = 62;
    localparam int unsigned NMax = MaxInserted + 2;
    localparam logic [15:0] PpmReset = 16'd256;

    typedef enum logic [2:0] {
        t_st_idle,
        t_st_sqrt,
        t_st_len,
        t_st_emit_a,
        t_st_div,
        t_st_emit_q,
        t_st_emit_b
    } t_state;
endpackage
`default_nettype wire

// ===== rtl/core/wpi_if.sv =====
`default_nettype none
interface wpi_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic        is_final;
    modport source (output valid, pos_x, pos_y, is_final, input ready);
    modport sink   (input valid, pos_x, pos_y, is_final, output ready);
endinterface

interface wpi_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [15:0] seq_num;
    logic        run_end;
    modport source (output valid, out_x, out_y, seq_num, run_end, input ready);
    modport sink   (input valid, out_x, out_y, seq_num, run_end, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/waypoint_interpolator_unit.sv =====
`default_nettype none
// With a previous waypoint the first word is presented after a serial square root, or
// without the root when the density is zero or the span is huge. Each interpolated point
// then needs two serial divisions, x then y. A waypoint is accepted only in the idle state
// with the output register free, so a segment is emitted in full before the next waypoint
// is taken; output stalls hold the emit states. A lone final waypoint is emitted as itself.
// Reset (synchronous, active low) clears path state and sets 1.0.
module waypoint_interpolator_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    wpi_in_if.sink           i_in,
    wpi_out_if.source        o_out
);
    wpi_pkg::t_state r_state, n_state;

    logic [15:0] r_ppm;
    logic [31:0] r_ax, r_ay, r_bx, r_by;
    logic        r_have, r_fin;
    logic [15:0] r_seq;
    logic [32:0] r_ux, r_uy;
    logic        r_sx, r_sy;
    logic [6:0]  r_n, r_j;
    logic        r_axis;
    logic [31:0] r_qx, r_qy;
    logic        r_ovalid;
    logic [31:0] r_ox, r_oy;
    logic [15:0] r_oseq;
    logic        r_oend;
    logic [47:0] r_prod;

    logic        w_acc, w_ofree, w_emit, w_long;
    logic [32:0] w_dx, w_dy;
    logic [61:0] w_sqx, w_sqy;
    logic [63:0] w_sq;
    logic        w_sq_start, w_sq_done;
    logic [31:0] w_root;
    logic        w_dv_start, w_dv_done;
    logic [38:0] w_num, w_quo;
    logic [32:0] w_u;
    logic [6:0]  w_jn;
    logic [31:0] w_a, w_res;
    logic        w_s;
    logic [6:0]  w_nn;
    logic [31:0] w_nsh;

    // Length times density, with the root widened to the product.
    function automatic logic [47:0] r_root_ext(input logic [31:0] root);
        r_root_ext = {16'd0, root};
    endfunction

    assign w_ofree = !r_ovalid || o_out.ready;
    assign i_in.ready = (r_state == wpi_pkg::t_st_idle) && w_ofree;
    assign w_acc = i_in.valid && i_in.ready;

    // A word is loaded into the output register in any emit state with room.
    assign w_emit = w_ofree && ((r_state == wpi_pkg::t_st_emit_a)
                             || (r_state == wpi_pkg::t_st_emit_q)
                             || (r_state == wpi_pkg::t_st_emit_b));

    // Differences of the new waypoint from the previous one.
    assign w_dx = {i_in.pos_x[31], i_in.pos_x} - {r_ax[31], r_ax};
    assign w_dy = {i_in.pos_y[31], i_in.pos_y} - {r_ay[31], r_ay};

    // A magnitude of 2^31 or more saturates the count without a root.
    assign w_long = (r_ux[32:31] != 2'b00) || (r_uy[32:31] != 2'b00);

    // Sum of squares, only needed when both magnitudes fit in 31 bits.
    assign w_sqx = {31'd0, r_ux[30:0]} * {31'd0, r_ux[30:0]};
    assign w_sqy = {31'd0, r_uy[30:0]} * {31'd0, r_uy[30:0]};
    assign w_sq  = {2'b00, w_sqx} + {2'b00, w_sqy};

    wpi_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_sq_start), .i_val(w_sq),
        .o_done(w_sq_done), .o_root(w_root)
    );

    // Division numerator j * |d|: x starts from an emit state, y as x finishes.
    assign w_jn  = (r_state == wpi_pkg::t_st_emit_q) ? r_j + 7'd1 : r_j;
    assign w_u   = (r_state == wpi_pkg::t_st_div) ? r_uy : r_ux;
    assign w_num = {32'd0, w_jn} * {6'd0, w_u};
    wpi_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dv_start), .i_num(w_num),
        .i_den(r_n), .o_done(w_dv_done), .o_quo(w_quo)
    );
    assign w_a   = r_axis ? r_ay : r_ax;
    assign w_s   = r_axis ? r_sy : r_sx;
    assign w_res = w_s ? (w_a - w_quo[31:0]) : (w_a + w_quo[31:0]);

    // Saturated point count from the scaled length.
    assign w_nsh = 32'(r_prod >> 24);
    assign w_nn  = (w_nsh > 32'(wpi_pkg::NMax)) ? 7'(wpi_pkg::NMax) : w_nsh[6:0];

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wpi_pkg::t_st_idle: begin
                if (w_acc) begin
                    if (!r_have) n_state = i_in.is_final ? wpi_pkg::t_st_emit_b
                                                         : wpi_pkg::t_st_idle;
                    else n_state = wpi_pkg::t_st_sqrt;
                end
            end
            wpi_pkg::t_st_sqrt: begin
                if (r_ppm == 16'd0) n_state = wpi_pkg::t_st_emit_a;
                else if (w_long) n_state = wpi_pkg::t_st_emit_a;
                else if (w_sq_done) n_state = wpi_pkg::t_st_len;
            end
            wpi_pkg::t_st_len:    n_state = wpi_pkg::t_st_emit_a;
            wpi_pkg::t_st_emit_a: begin
                if (w_ofree) begin
                    if (r_n >= 7'd3) n_state = wpi_pkg::t_st_div;
                    else if (r_fin) n_state = wpi_pkg::t_st_emit_b;
                    else n_state = wpi_pkg::t_st_idle;
                end
            end
            wpi_pkg::t_st_div: begin
                if (w_dv_done && r_axis) n_state = wpi_pkg::t_st_emit_q;
            end
            wpi_pkg::t_st_emit_q: begin
                if (w_ofree) begin
                    if (r_j + 7'd3 < r_n) n_state = wpi_pkg::t_st_div;
                    else if (r_fin) n_state = wpi_pkg::t_st_emit_b;
                    else n_state = wpi_pkg::t_st_idle;
                end
            end
            wpi_pkg::t_st_emit_b: if (w_ofree) n_state = wpi_pkg::t_st_idle;
            default: n_state = wpi_pkg::t_st_idle;
        endcase
    end

    // Unit start strobes. The root is started only when its result is used.
    always_comb begin
        w_sq_start = 1'b0;
        w_dv_start = 1'b0;
        if (r_state == wpi_pkg::t_st_sqrt && r_j == 7'd0 && r_ppm != 16'd0 && !w_long)
            w_sq_start = 1'b1;
        if (r_state == wpi_pkg::t_st_emit_a && w_ofree && r_n >= 7'd3) w_dv_start = 1'b1;
        if (r_state == wpi_pkg::t_st_emit_q && w_ofree && r_j + 7'd3 < r_n) w_dv_start = 1'b1;
        if (r_state == wpi_pkg::t_st_div && w_dv_done && !r_axis) w_dv_start = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= wpi_pkg::t_st_idle;
            r_ppm    <= wpi_pkg::PpmReset;
            r_have   <= 1'b0;
            r_seq    <= '0;
            r_ax     <= '0;
            r_ay     <= '0;
            r_ovalid <= 1'b0;
            r_j      <= '0;
            r_axis   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_ppm <= i_cfg_wdata;
            r_ovalid <= w_emit || (r_ovalid && !o_out.ready);
            unique case (r_state)
                wpi_pkg::t_st_idle: begin
                    if (w_acc) begin
                        r_bx  <= i_in.pos_x;
                        r_by  <= i_in.pos_y;
                        r_fin <= i_in.is_final;
                        r_ux  <= w_dx[32] ? -w_dx : w_dx;
                        r_uy  <= w_dy[32] ? -w_dy : w_dy;
                        r_sx  <= w_dx[32];
                        r_sy  <= w_dy[32];
                        r_n   <= '0;
                        r_j   <= '0;
                        if (!i_in.is_final) begin
                            if (!r_have) begin
                                r_ax <= i_in.pos_x;
                                r_ay <= i_in.pos_y;
                            end
                            r_have <= 1'b1;
                        end
                    end
                end
                wpi_pkg::t_st_sqrt: begin
                    // r_j doubles as the "square root started" flag here.
                    if (r_ppm == 16'd0) begin
                        r_n <= '0;
                        r_j <= '0;
                    end else if (w_long) begin
                        r_n <= 7'(wpi_pkg::NMax);
                        r_j <= '0;
                    end else if (w_sq_done) begin
                        r_prod <= r_root_ext(w_root) * r_ppm;
                        r_j    <= '0;
                    end else begin
                        r_j <= 7'd1;
                    end
                end
                wpi_pkg::t_st_len: r_n <= w_nn;
                wpi_pkg::t_st_emit_a: begin
                    if (w_ofree) begin
                        r_ox     <= r_ax;
                        r_oy     <= r_ay;
                        r_oseq   <= r_seq;
                        r_oend   <= !(r_n >= 7'd3) && !r_fin;
                        r_seq    <= r_seq + 16'd1;
                        r_axis   <= 1'b0;
                        if (!(r_n >= 7'd3) && !r_fin) begin
                            r_ax <= r_bx;
                            r_ay <= r_by;
                        end
                    end
                end
                wpi_pkg::t_st_div: begin
                    if (w_dv_done) begin
                        if (!r_axis) r_qx <= w_res;
                        else r_qy <= w_res;
                        r_axis <= !r_axis;
                    end
                end
                wpi_pkg::t_st_emit_q: begin
                    if (w_ofree) begin
                        r_ox     <= r_qx;
                        r_oy     <= r_qy;
                        r_oseq   <= r_seq;
                        r_oend   <= !(r_j + 7'd3 < r_n) && !r_fin;
                        r_seq    <= r_seq + 16'd1;
                        r_j      <= r_j + 7'd1;
                        if (!(r_j + 7'd3 < r_n) && !r_fin) begin
                            r_ax <= r_bx;
                            r_ay <= r_by;
                        end
                    end
                end
                wpi_pkg::t_st_emit_b: begin
                    if (w_ofree) begin
                        r_ox     <= r_bx;
                        r_oy     <= r_by;
                        r_oseq   <= r_seq;
                        r_oend   <= 1'b1;
                        r_seq    <= '0;
                        r_have   <= 1'b0;
                        r_ax     <= r_bx;
                        r_ay     <= r_by;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out.valid   = r_ovalid;
    assign o_out.out_x   = r_ox;
    assign o_out.out_y   = r_oy;
    assign o_out.seq_num = r_oseq;
    assign o_out.run_end = r_oend;
endmodule
`default_nettype wire

// ===== rtl/core/wpi_sqrt.sv =====
`default_nettype none
// Bit-serial integer square root: one result bit per cycle.
module wpi_sqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_val,
    output logic             o_done,
    output logic [31:0]      o_root
);
    logic [63:0] r_val;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [33:0] w_rem_sh;
    logic [33:0] w_trial;

    // Shift in two radicand bits and try the next root bit.
    assign w_rem_sh = {r_rem[31:0], r_val[63:62]};
    assign w_trial  = {r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
                r_val  <= i_val;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_val <= {r_val[61:0], 2'b00};
                if (w_rem_sh >= w_trial) begin
                    r_rem  <= w_rem_sh - w_trial;
                    r_root <= {r_root[30:0], 1'b1};
                end else begin
                    r_rem  <= w_rem_sh;
                    r_root <= {r_root[30:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_root = r_root;
endmodule
`default_nettype wire

// ===== rtl/core/wpi_div.sv =====
`default_nettype none
// Restoring divider for a 39-bit numerator by a 7-bit divisor, one quotient
// bit per cycle.
module wpi_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [38:0] i_num,
    input  wire logic [6:0]  i_den,
    output logic             o_done,
    output logic [38:0]      o_quo
);
    logic [38:0] r_num;
    logic [7:0]  r_rem;
    logic [6:0]  r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [7:0]  w_sh;

    assign w_sh = {r_rem[6:0], r_num[38]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                if (w_sh >= {1'b0, r_den}) begin
                    r_rem <= w_sh - {1'b0, r_den};
                    r_num <= {r_num[37:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_num <= {r_num[37:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd38) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quo = r_num;
endmodule
`default_nettype wire

// ===== bench/waypoint_interpolator_unit_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
module waypoint_interpolator_unit_tb;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [15:0] seq;
        logic        last;
    } t_point;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic        fin;
        logic        typed;   // row carries a typed-in expectation
        logic [31:0] ex_x;
        logic [31:0] ex_y;
    } t_row;

    localparam int unsigned CycleLimit = 10000000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [15:0] i_cfg_wdata;

    wpi_in_if  in_ch ();
    wpi_out_if out_ch ();

    waypoint_interpolator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source)
    );

    // Predictor state, a copy of the block's path state.
    logic [15:0] density;
    logic [31:0] last_x;
    logic [31:0] last_y;
    logic        path_open;
    logic [15:0] seq_count;

    t_point pending_points[$];
    int unsigned mismatches;
    int unsigned cycles;
    logic hold_off;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    t_row rows[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CycleLimit) begin
                $display("waypoint_interpolator_unit_tb: done, errors");
                $finish;
            end
        end
    end

    function automatic logic [63:0] root_of(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] along(input logic signed [33:0] a,
                                          input logic signed [33:0] d,
                                          input logic [63:0] j, input logic [63:0] n);
        logic [63:0] mag;
        logic [63:0] q;
        logic signed [33:0] r;
        mag = d < 0 ? 64'(-d) : 64'(d);
        q = (j * mag) / n;
        r = d < 0 ? a - 34'(q) : a + 34'(q);
        return r[31:0];
    endfunction

    task automatic push_point(input logic [31:0] x, input logic [31:0] y);
        t_point p;
        p.x = x;
        p.y = y;
        p.seq = seq_count;
        p.last = 1'b0;
        pending_points = {pending_points, p};
        seq_count = seq_count + 16'd1;
    endtask

    // Works out the points one accepted waypoint causes.
    task automatic predict_waypoint(input logic [31:0] bx, input logic [31:0] by,
                                    input logic fin);
        logic signed [33:0] ax, ay, dx, dy;
        logic [63:0] ux, uy, n, len;
        int start;
        start = pending_points.size();
        if (path_open) begin
            ax = 34'(signed'(last_x));
            ay = 34'(signed'(last_y));
            dx = 34'(signed'(bx)) - ax;
            dy = 34'(signed'(by)) - ay;
            ux = dx < 0 ? 64'(-dx) : 64'(dx);
            uy = dy < 0 ? 64'(-dy) : 64'(dy);
            if (density == 0) begin
                n = 0;
            end else if (ux >= 64'h8000_0000 || uy >= 64'h8000_0000) begin
                n = wpi_pkg::NMax;
            end else begin
                len = root_of(ux * ux + uy * uy);
                n = (len * density) >> 24;
                if (n > wpi_pkg::NMax) n = wpi_pkg::NMax;
            end
            push_point(last_x, last_y);
            for (longint j = 0; n >= 3 && j < n - 2; j++)
                push_point(along(ax, dx, j, n), along(ay, dy, j, n));
        end
        if (fin) begin
            push_point(bx, by);
            path_open = 1'b0;
            seq_count = 16'd0;
        end else begin
            path_open = 1'b1;
        end
        last_x = bx;
        last_y = by;
        if (pending_points.size() > start)
            pending_points[pending_points.size() - 1].last = 1'b1;
    endtask

    // Receiver: random stalls, a long hold-off on request, and checks each word.
    initial begin
        t_point want;
        out_ch.ready <= 1'b0;
        mismatches = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                if (pending_points.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word x=%h y=%h seq=%0d", out_ch.out_x,
                                 out_ch.out_y, out_ch.seq_num);
                end else begin
                    want = pending_points.pop_front();
                    if (out_ch.out_x !== want.x || out_ch.out_y !== want.y
                        || out_ch.seq_num !== want.seq || out_ch.run_end !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp x=%h y=%h seq=%0d end=%b,",
                                      " got x=%h y=%h seq=%0d end=%b"},
                                     want.x, want.y, want.seq, want.last, out_ch.out_x,
                                     out_ch.out_y, out_ch.seq_num, out_ch.run_end);
                    end
                end
            end
            out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Long receiver hold-off, counted here.
    task automatic stall_receiver(input int unsigned len);
        hold_off = 1'b1;
        repeat (len) @(posedge i_clk);
        hold_off = 1'b0;
    endtask

    // Offers one waypoint; valid stays up after acceptance until the next call or a drain.
    task automatic send_waypoint(input logic [31:0] x, input logic [31:0] y,
                                 input logic fin);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.pos_x <= x;
        in_ch.pos_y <= y;
        in_ch.is_final <= fin;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_waypoint(x, y, fin);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic set_density(input logic [15:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        density = v;
    endtask

    function automatic logic [31:0] rand_coord(input int unsigned kind);
        case (kind)
            0: return $urandom;
            1: return 32'($signed($urandom_range(2000000)) - 1000000);
            default: return 32'($signed($urandom_range(6000000)) - 3000000);
        endcase
    endfunction

    task automatic add_row(input logic [31:0] x, input logic [31:0] y, input logic fin,
                           input logic typed = 1'b0, input logic [31:0] ex = 32'd0,
                           input logic [31:0] ey = 32'd0);
        t_row r;
        r.x = x; r.y = y; r.fin = fin; r.typed = typed; r.ex_x = ex; r.ex_y = ey;
        rows = {rows, r};
    endtask

    initial begin
        int unsigned plen;
        int unsigned kind;
        logic [15:0] dens_set[5];
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 16'd0;
        in_ch.valid = 1'b0;
        in_ch.pos_x = 32'd0;
        in_ch.pos_y = 32'd0;
        in_ch.is_final = 1'b0;
        hold_off = 1'b0;
        send_idle_pct = 37;
        recv_idle_pct = 81;
        density = wpi_pkg::PpmReset;
        last_x = 0; last_y = 0; path_open = 0; seq_count = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: single-waypoint path, extremes, short and long segments.
        add_row(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000);
        add_row(32'h0000_0000, 32'h0000_0000, 1'b0);
        add_row(32'h0000_0000, 32'h0000_0000, 1'b0);          // empty segment
        add_row(32'h0001_0000, 32'h0000_0000, 1'b0);          // short segment
        add_row(32'h000A_0000, 32'h0005_0000, 1'b0);          // a few points
        add_row(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);          // very long, saturates
        add_row(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        add_row(32'h0003_0000, 32'hFFFD_0000, 1'b0);
        add_row(32'hFFEC_0000, 32'h0014_0000, 1'b1);          // negative direction
        foreach (rows[i]) begin
            if (rows[i].typed) begin
                t_point p;
                send_waypoint(rows[i].x, rows[i].y, rows[i].fin);
                // Typed row: a lone final waypoint comes back as itself.
                p = pending_points[pending_points.size() - 1];
                if (p.x !== rows[i].ex_x || p.y !== rows[i].ex_y || p.seq !== 0
                    || !p.last) begin
                    mismatches++;
                    $display("typed row %0d disagrees with predictor", i);
                end
            end else begin
                send_waypoint(rows[i].x, rows[i].y, rows[i].fin);
            end
        end

        // Density extremes.
        set_density(16'd0);
        send_waypoint(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_waypoint(32'h8000_0000, 32'h0000_0000, 1'b0);
        send_waypoint(32'h0010_0000, 32'h0000_0000, 1'b1);
        set_density(16'hFFFF);
        send_waypoint(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_waypoint(32'h0000_8000, 32'h0000_4000, 1'b0);
        send_waypoint(32'h0000_0000, 32'h0001_0000, 1'b1);

        // Pressure: long receiver hold-off while waypoints keep coming.
        set_density(16'd2048);
        fork
            stall_receiver(3000);
            begin
                send_waypoint(32'h0000_0000, 32'h0000_0000, 1'b0);
                send_waypoint(32'h0020_0000, 32'h0010_0000, 1'b0);
                send_waypoint(32'hFFE0_0000, 32'h0000_0000, 1'b1);
            end
        join
        drain();

        // Random paths, three idling phases and several densities.
        dens_set = '{16'd256, 16'd0, 16'hFFFF, 16'd1024, 16'd17};
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = ph == 0 ? 37 : (ph == 1 ? 81 : 0);
            recv_idle_pct = ph == 0 ? 81 : (ph == 1 ? 37 : 0);
            for (int d = 0; d < 5; d++) begin
                set_density(d == 0 ? 16'($urandom) : dens_set[d]);
                for (int p = 0; p < 6; p++) begin
                    plen = $urandom_range(5, 1);
                    kind = $urandom_range(9) == 0 ? 0 : $urandom_range(2, 1);
                    for (int w = 0; w < plen; w++)
                        send_waypoint(rand_coord(kind), rand_coord(kind),
                                      (w == plen - 1) && ($urandom_range(7) != 0));
                end
            end
        end

        drain();
        if (mismatches == 0 && pending_points.size() == 0)
            $display("waypoint_interpolator_unit_tb: done, clean");
        else
            $display("waypoint_interpolator_unit_tb: done, errors");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/core/wpi_pkg.sv
rtl/core/wpi_if.sv
rtl/core/wpi_sqrt.sv
rtl/core/wpi_div.sv
rtl/core/waypoint_interpolator_unit.sv
bench/waypoint_interpolator_unit_tb.sv
